// ----- rtl/ccp_pkg.sv -----
package ccp_pkg;

  localparam int unsigned LINE_BYTES_DEF = 32;
  localparam int unsigned GRID_CELLS_DEF = 8;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned FRAME_W  = 12;
  localparam int unsigned MAG_W    = 16;
  localparam int unsigned CELL_W   = 3;
  localparam int unsigned STATUS_W = 2;

  localparam logic [MAG_W-1:0]   MAG_MAX          = 16'hFFFF;
  localparam logic [FRAME_W-1:0] FRAME_WIDTH_RST  = 12'd160;
  localparam logic [FRAME_W-1:0] FRAME_HEIGHT_RST = 12'd120;
  localparam int unsigned        TARGET_RST       = 3;

  localparam logic [BYTE_W-1:0] CH_NUL   = 8'h00;
  localparam logic [BYTE_W-1:0] CH_TAB   = 8'h09;
  localparam logic [BYTE_W-1:0] CH_NL    = 8'h0A;
  localparam logic [BYTE_W-1:0] CH_CR    = 8'h0D;
  localparam logic [BYTE_W-1:0] CH_SPACE = 8'h20;
  localparam logic [BYTE_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [BYTE_W-1:0] CH_COMMA = 8'h2C;
  localparam logic [BYTE_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [BYTE_W-1:0] CH_ZERO  = 8'h30;
  localparam logic [BYTE_W-1:0] CH_NINE  = 8'h39;

  typedef enum logic [2:0] {
    PH_X_WS,
    PH_X_SIGN,
    PH_X_DIG,
    PH_Y_WS,
    PH_Y_SIGN,
    PH_Y_DIG,
    PH_DONE,
    PH_FAIL
  } phase_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_CHECK,
    S_DIV,
    S_OUT
  } seq_e;

  typedef enum logic [STATUS_W-1:0] {
    STAT_UPDATED,
    STAT_EMPTY,
    STAT_PARSE_FAIL,
    STAT_RANGE
  } status_e;

  typedef enum logic [0:0] {
    REG_FRAME_WIDTH,
    REG_FRAME_HEIGHT
  } reg_idx_e;

  function automatic logic is_space(input logic [BYTE_W-1:0] c);
    return (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
  endfunction

  function automatic logic is_digit(input logic [BYTE_W-1:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

endpackage

// ----- rtl/coordinate_command_parser_unit.sv -----
// channel  | valid       | stall       | payload
// ---------+-------------+-------------+------------------------------------
// request  | in_valid_i  | in_stall_o  | rx_byte_i
// result   | out_valid_o | out_stall_i | cell_col_o, cell_row_o, line_status_o
// config   | cfg_we_i    | -           | cfg_idx_i, cfg_data_i
//
// a byte that does not end a line is taken with no stall
// a line end goes through a check state, then through the
// shared compare-subtract divider when the target is updated, then the result
// is held until taken; the input stalls from line end until the result goes
// reset puts frame size at 160x120, target cell at 3,3 and clears the line
module coordinate_command_parser_unit
  import ccp_pkg::*;
#(
  parameter int unsigned LINE_BYTES = LINE_BYTES_DEF,
  parameter int unsigned GRID_CELLS = GRID_CELLS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  logic [BYTE_W-1:0]   rx_byte_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output logic [CELL_W-1:0]   cell_col_o,
  output logic [CELL_W-1:0]   cell_row_o,
  output logic [STATUS_W-1:0] line_status_o,
  input  logic                cfg_we_i,
  input  logic [0:0]          cfg_idx_i,
  input  logic [FRAME_W-1:0]  cfg_data_i
);

  localparam int unsigned CW = $clog2(LINE_BYTES);
  localparam int unsigned QW = $clog2(GRID_CELLS);
  localparam int unsigned TW = (QW > CELL_W) ? QW : CELL_W;
  localparam int unsigned SW = (QW > 1) ? $clog2(QW) : 1;
  localparam int unsigned DW = FRAME_W + QW;
  localparam int unsigned PW = MAG_W + 4;

  seq_e                 state_q, state_d;
  phase_e               phase_q, phase_d;
  logic [MAG_W-1:0]     x_q, x_d, y_q, y_d;
  logic                 xneg_q, xneg_d, yneg_q, yneg_d;
  logic [CW-1:0]        cnt_q, cnt_d;
  logic [TW-1:0]        tcol_q, tcol_d, trow_q, trow_d;
  logic [FRAME_W-1:0]   width_q, height_q;
  status_e              status_q, status_d;
  logic [DW-1:0]        rem_q, rem_d;
  logic [TW-1:0]        quo_q, quo_d;
  logic [SW-1:0]        step_q, step_d;
  logic                 sel_q, sel_d;

  logic                 acc_is_y;
  logic [MAG_W-1:0]     acc;
  logic [PW-1:0]        prod;
  logic [MAG_W-1:0]     acc_next;
  logic [FRAME_W-1:0]   mul_in;
  logic [DW-1:0]        mul_out;
  logic [DW-1:0]        div_shift;
  logic                 fits;
  logic [TW-1:0]        quo_next;
  logic                 x_bad, y_bad;

  // shared digit accumulator: v*10 + d, saturating
  always_comb begin
    acc_is_y = (phase_q == PH_Y_WS) || (phase_q == PH_Y_SIGN) || (phase_q == PH_Y_DIG);
    acc      = acc_is_y ? y_q : x_q;
    prod     = {acc, 3'b000} + {2'b00, acc, 1'b0} + PW'(rx_byte_i[3:0]);
    acc_next = (prod > PW'(MAG_MAX)) ? MAG_MAX : prod[MAG_W-1:0];
  end

  // shared multiplier and compare-subtract divider
  always_comb begin
    mul_in    = (state_q == S_CHECK) ? x_q[FRAME_W-1:0] : y_q[FRAME_W-1:0];
    mul_out   = DW'(mul_in) * DW'(GRID_CELLS);
    div_shift = DW'(sel_q ? height_q : width_q) << step_q;
    fits      = rem_q >= div_shift;
    quo_next  = {quo_q[TW-2:0], fits};
    x_bad     = (xneg_q && (x_q != '0)) || (x_q >= MAG_W'(width_q));
    y_bad     = (yneg_q && (y_q != '0)) || (y_q >= MAG_W'(height_q));
  end

  always_comb begin
    state_d  = state_q;
    phase_d  = phase_q;
    x_d      = x_q;
    y_d      = y_q;
    xneg_d   = xneg_q;
    yneg_d   = yneg_q;
    cnt_d    = cnt_q;
    tcol_d   = tcol_q;
    trow_d   = trow_q;
    status_d = status_q;
    rem_d    = rem_q;
    quo_d    = quo_q;
    step_d   = step_q;
    sel_d    = sel_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (rx_byte_i == CH_NL) begin
            state_d = S_CHECK;
          end else begin
            cnt_d = cnt_q + 1'b1;
            if (cnt_d == CW'(LINE_BYTES - 1)) begin
              state_d = S_CHECK;
            end
            if ((phase_q != PH_DONE) && (phase_q != PH_FAIL)) begin
              if (rx_byte_i == CH_NUL) begin
                phase_d = (phase_q == PH_Y_DIG) ? PH_DONE : PH_FAIL;
              end else begin
                unique case (phase_q)
                  PH_X_WS, PH_Y_WS: begin
                    if (is_space(rx_byte_i)) begin
                      phase_d = phase_q;
                    end else if ((rx_byte_i == CH_PLUS) || (rx_byte_i == CH_MINUS)) begin
                      if (acc_is_y) begin
                        yneg_d  = rx_byte_i == CH_MINUS;
                        phase_d = PH_Y_SIGN;
                      end else begin
                        xneg_d  = rx_byte_i == CH_MINUS;
                        phase_d = PH_X_SIGN;
                      end
                    end else if (is_digit(rx_byte_i)) begin
                      if (acc_is_y) begin
                        y_d     = acc_next;
                        phase_d = PH_Y_DIG;
                      end else begin
                        x_d     = acc_next;
                        phase_d = PH_X_DIG;
                      end
                    end else begin
                      phase_d = PH_FAIL;
                    end
                  end
                  PH_X_SIGN, PH_Y_SIGN: begin
                    if (is_digit(rx_byte_i)) begin
                      if (acc_is_y) begin
                        y_d     = acc_next;
                        phase_d = PH_Y_DIG;
                      end else begin
                        x_d     = acc_next;
                        phase_d = PH_X_DIG;
                      end
                    end else begin
                      phase_d = PH_FAIL;
                    end
                  end
                  PH_X_DIG: begin
                    if (is_digit(rx_byte_i)) begin
                      x_d = acc_next;
                    end else if (rx_byte_i == CH_COMMA) begin
                      phase_d = PH_Y_WS;
                    end else begin
                      phase_d = PH_FAIL;
                    end
                  end
                  PH_Y_DIG: begin
                    if (is_digit(rx_byte_i)) begin
                      y_d = acc_next;
                    end else begin
                      phase_d = PH_DONE;
                    end
                  end
                  PH_DONE, PH_FAIL: begin
                    phase_d = phase_q;
                  end
                endcase
              end
            end
          end
        end
      end

      S_CHECK: begin
        priority if (cnt_q == '0) begin
          status_d = STAT_EMPTY;
        end else if ((phase_q != PH_Y_DIG) && (phase_q != PH_DONE)) begin
          status_d = STAT_PARSE_FAIL;
        end else if (x_bad || y_bad) begin
          status_d = STAT_RANGE;
        end else begin
          status_d = STAT_UPDATED;
        end
        if (status_d == STAT_UPDATED) begin
          sel_d   = 1'b0;
          rem_d   = mul_out;
          quo_d   = '0;
          step_d  = SW'(QW - 1);
          state_d = S_DIV;
        end else begin
          state_d = S_OUT;
        end
      end

      S_DIV: begin
        if (fits) begin
          rem_d = rem_q - div_shift;
        end
        quo_d  = quo_next;
        step_d = step_q - 1'b1;
        if (step_q == '0) begin
          if (!sel_q) begin
            tcol_d = quo_next;
            sel_d  = 1'b1;
            rem_d  = mul_out;
            quo_d  = '0;
            step_d = SW'(QW - 1);
          end else begin
            trow_d  = quo_next;
            state_d = S_OUT;
          end
        end
      end

      S_OUT: begin
        if (!out_stall_i) begin
          state_d = S_IDLE;
        end
      end
    endcase

    // line buffer is cleared as the result is presented
    if ((state_q != S_OUT) && (state_d == S_OUT)) begin
      phase_d = PH_X_WS;
      x_d     = '0;
      y_d     = '0;
      xneg_d  = 1'b0;
      yneg_d  = 1'b0;
      cnt_d   = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      phase_q <= PH_X_WS;
      x_q     <= '0;
      y_q     <= '0;
      xneg_q  <= 1'b0;
      yneg_q  <= 1'b0;
      cnt_q   <= '0;
      tcol_q  <= TW'(TARGET_RST);
      trow_q  <= TW'(TARGET_RST);
      step_q  <= '0;
      sel_q   <= 1'b0;
    end else begin
      state_q <= state_d;
      phase_q <= phase_d;
      x_q     <= x_d;
      y_q     <= y_d;
      xneg_q  <= xneg_d;
      yneg_q  <= yneg_d;
      cnt_q   <= cnt_d;
      tcol_q  <= tcol_d;
      trow_q  <= trow_d;
      step_q  <= step_d;
      sel_q   <= sel_d;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    rem_q    <= rem_d;
    quo_q    <= quo_d;
  end

  // frame size registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= FRAME_WIDTH_RST;
      height_q <= FRAME_HEIGHT_RST;
    end else if (cfg_we_i) begin
      unique case (reg_idx_e'(cfg_idx_i))
        REG_FRAME_WIDTH:  width_q  <= cfg_data_i;
        REG_FRAME_HEIGHT: height_q <= cfg_data_i;
      endcase
    end
  end

  assign in_stall_o    = state_q != S_IDLE;
  assign out_valid_o   = state_q == S_OUT;
  assign cell_col_o    = tcol_q[CELL_W-1:0];
  assign cell_row_o    = trow_q[CELL_W-1:0];
  assign line_status_o = status_q;

endmodule
